/* src/mbbf_pkg.sv */
// shared types, register codes and arithmetic helpers for the bandpass boost filter
// no dependencies; imported by the controller, the datapath, the top level and both testbenches
`default_nettype none

package mbbf_pkg;

    // configuration register indexes
    typedef logic [2:0] cfg_addr_t;
    localparam cfg_addr_t REG_FILTER_ENABLE = 3'd0;
    localparam cfg_addr_t REG_COEF_W        = 3'd1;
    localparam cfg_addr_t REG_COEF_A1       = 3'd2;
    localparam cfg_addr_t REG_COEF_A2       = 3'd3;
    localparam cfg_addr_t REG_COEF_INV_A0   = 3'd4;
    localparam cfg_addr_t REG_BOOST_GAIN    = 3'd5;

    localparam int COEF_BITS = 32;
    localparam int FRAC_BITS = 24;

    // half an lsb of the q40.24 product, for round half up
    localparam logic signed [63:0] ROUND_HALF = 64'sd8388608;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL_W,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_SUB_A2,
        ST_MUL_NORM,
        ST_STORE,
        ST_MUL_GAIN,
        ST_OUT,
        ST_PASS
    } state_t;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_W,
        MUL_A1,
        MUL_A2,
        MUL_NORM,
        MUL_GAIN
    } mul_sel_t;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } acc_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load_in;
        logic     load_diff;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     store;
        logic     out_load;
        logic     out_pass;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic enable;
    } dp_status_t;

    // saturate a wide signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat_to32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -42'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/mbbf_datapath.sv */
// datapath: configuration registers, per-channel history memory, shared multiplier,
// accumulator and output register; depends on mbbf_pkg
`default_nettype none

module mbbf_datapath #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire mbbf_pkg::cfg_addr_t     cfg_addr,
    input  wire [31:0]                   cfg_wdata,
    input  wire signed [SAMPLE_BITS-1:0] s_sample_in,
    input  wire [2:0]                    s_chan_index,
    input  wire mbbf_pkg::dp_cmd_t       cmd,
    output mbbf_pkg::dp_status_t         status,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out
);
    import mbbf_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int HW   = 2 * SAMPLE_BITS + 2 * COEF_BITS;
    localparam logic [6:0] NCH = 7'(NUM_CHANNELS);
    localparam logic signed [39:0] OUT_MAX =
        40'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [39:0] OUT_MIN = ~OUT_MAX;

    // configuration registers
    logic              enable_reg;
    logic signed [31:0] coef_w_reg, coef_a1_reg, coef_a2_reg, coef_inv_a0_reg, boost_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b0;
            coef_w_reg      <= '0;
            coef_a1_reg     <= '0;
            coef_a2_reg     <= '0;
            coef_inv_a0_reg <= '0;
            boost_gain_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FILTER_ENABLE: enable_reg      <= cfg_wdata[0];
                REG_COEF_W:        coef_w_reg      <= cfg_wdata;
                REG_COEF_A1:       coef_a1_reg     <= cfg_wdata;
                REG_COEF_A2:       coef_a2_reg     <= cfg_wdata;
                REG_COEF_INV_A0:   coef_inv_a0_reg <= cfg_wdata;
                REG_BOOST_GAIN:    boost_gain_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign status.enable = enable_reg;

    // channel index folded into the channel range
    logic [6:0]      chan_fold;
    logic [CH_W-1:0] rd_idx;

    always_comb begin
        chan_fold = {4'b0000, s_chan_index};
        for (int i = 0; i < 7; i++) begin
            if (chan_fold >= NCH) begin
                chan_fold = chan_fold - NCH;
            end
        end
        rd_idx = chan_fold[CH_W-1:0];
    end

    // input beat capture
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [CH_W-1:0]               chan_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg    <= s_sample_in;
            chan_reg <= rd_idx;
        end
    end

    // history memory: {x1, x2, z1, z2} per channel, registered read
    logic [HW-1:0]     hist_mem [NUM_CHANNELS];
    logic [HW-1:0]     rd_word_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic              rd_valid_reg;
    logic [HW-1:0]     wr_word;

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            hist_mem[chan_reg] <= wr_word;
        end
        if (cmd.load_in) begin
            rd_word_reg <= hist_mem[rd_idx];
        end
    end

    // valid bits make never-written channels read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.store) begin
                valid_reg[chan_reg] <= 1'b1;
            end
            if (cmd.load_in) begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    logic [HW-1:0] hist_word;
    logic signed [SAMPLE_BITS-1:0] h_x1, h_x2;
    logic signed [31:0]            h_z1, h_z2;

    assign hist_word = rd_valid_reg ? rd_word_reg : '0;
    assign h_x1 = hist_word[HW-1 -: SAMPLE_BITS];
    assign h_x2 = hist_word[HW-SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign h_z1 = hist_word[63:32];
    assign h_z2 = hist_word[31:0];

    // input difference, saturated to 32 bits
    logic signed [31:0] diff_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_diff) begin
            diff_reg <= sat_to32(42'(x_reg) - 42'(h_x2));
        end
    end

    // shared multiplier with registered product
    logic signed [31:0] mul_a, mul_c;
    logic signed [63:0] prod_reg;
    logic signed [41:0] acc_reg;
    logic signed [31:0] v_reg;

    always_comb begin
        case (cmd.mul_sel)
            MUL_W:    begin mul_a = diff_reg;          mul_c = coef_w_reg;      end
            MUL_A1:   begin mul_a = h_z1;              mul_c = coef_a1_reg;     end
            MUL_A2:   begin mul_a = h_z2;              mul_c = coef_a2_reg;     end
            MUL_NORM: begin mul_a = sat_to32(acc_reg); mul_c = coef_inv_a0_reg; end
            MUL_GAIN: begin mul_a = v_reg;             mul_c = boost_gain_reg;  end
            default:  begin mul_a = '0;                mul_c = '0;              end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_sel != MUL_NONE) begin
            prod_reg <= 64'(mul_a) * 64'(mul_c);
        end
    end

    // round half up and drop the fraction
    logic signed [63:0] rnd_sum;
    logic signed [39:0] rnd;

    assign rnd_sum = prod_reg + ROUND_HALF;
    assign rnd     = rnd_sum[63:24];

    // accumulator for the feedback sum
    always_ff @(posedge aclk) begin
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= 42'(rnd);
            ACC_SUB:  acc_reg <= acc_reg - 42'(rnd);
            default:  ;
        endcase
    end

    // new band value and history write-back
    logic signed [31:0] v_next;

    assign v_next  = sat_to32(42'(rnd));
    assign wr_word = {x_reg, h_x1, v_next, h_z1};

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            v_reg <= v_next;
        end
    end

    // output register, saturated to the sample range
    logic signed [SAMPLE_BITS-1:0] out_sat;

    always_comb begin
        if (rnd > OUT_MAX) begin
            out_sat = OUT_MAX[SAMPLE_BITS-1:0];
        end else if (rnd < OUT_MIN) begin
            out_sat = OUT_MIN[SAMPLE_BITS-1:0];
        end else begin
            out_sat = rnd[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_sample_out <= cmd.out_pass ? x_reg : out_sat;
        end
    end

endmodule

`default_nettype wire

/* src/mbbf_ctrl.sv */
// controller: sequences the shared multiplier per sample and owns both handshakes
// depends on mbbf_pkg; drives mbbf_datapath through dp_cmd_t
`default_nettype none

module mbbf_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire                     m_ready,
    input  wire mbbf_pkg::dp_status_t status,
    output mbbf_pkg::dp_cmd_t       cmd
);
    import mbbf_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // state and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.load_in   = 1'b0;
        cmd.load_diff = 1'b0;
        cmd.mul_sel   = MUL_NONE;
        cmd.acc_op    = ACC_HOLD;
        cmd.store     = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.out_pass  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = status.enable ? ST_DIFF : ST_PASS;
                end
            end
            ST_DIFF: begin
                cmd.load_diff = 1'b1;
                state_next    = ST_MUL_W;
            end
            ST_MUL_W: begin
                cmd.mul_sel = MUL_W;
                state_next  = ST_MUL_A1;
            end
            ST_MUL_A1: begin
                cmd.mul_sel = MUL_A1;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_MUL_A2;
            end
            ST_MUL_A2: begin
                cmd.mul_sel = MUL_A2;
                cmd.acc_op  = ACC_SUB;
                state_next  = ST_SUB_A2;
            end
            ST_SUB_A2: begin
                cmd.acc_op = ACC_SUB;
                state_next = ST_MUL_NORM;
            end
            ST_MUL_NORM: begin
                cmd.mul_sel = MUL_NORM;
                state_next  = ST_STORE;
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN: begin
                cmd.mul_sel = MUL_GAIN;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_PASS: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_pass = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid follows loads and taken beats
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // a waiting result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while a beat is pending");

    // history only changes while filtering
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> status.enable)
        else $error("history written while the filter is disabled");

    // an accepted beat starts either the filter or the bypass path
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIFF || state_reg == ST_PASS))
        else $error("accepted beat did not start processing");

    // a result appears only from an output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT || $past(state_reg) == ST_PASS))
        else $error("result raised outside an output state");

endmodule

`default_nettype wire

/* src/multichannel_bandpass_boost_filter.sv */
// multichannel bandpass boost filter, top level: controller plus datapath
// filtering: an accepted beat goes through DIFF, MUL_W, MUL_A1, MUL_A2, SUB_A2, MUL_NORM,
// STORE, MUL_GAIN and OUT, the single shared 32x32 multiplier doing five products in
// sequence; bypass goes through PASS only; no new beat is taken until the result is loaded
// reset: synchronous active low; clears configuration, state and output-valid registers and
// the per-channel valid bits, so each channel history reads as zero at once, no clearing pass
`default_nettype none

module multichannel_bandpass_boost_filter #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire mbbf_pkg::cfg_addr_t     cfg_addr,
    input  wire [31:0]                   cfg_wdata,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire signed [SAMPLE_BITS-1:0] s_sample_in,
    input  wire [2:0]                    s_chan_index,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out
);
    import mbbf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mbbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mbbf_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_sample_in  (s_sample_in),
        .s_chan_index (s_chan_index),
        .cmd          (cmd),
        .status       (status),
        .m_sample_out (m_sample_out)
    );

endmodule

`default_nettype wire

/* test/mbbf_result_checker.sv */
// result checker for the multichannel bandpass boost filter: tracks register writes,
// predicts each output beat from the accepted input beats and compares in order
// depends on mbbf_pkg for the register index codes and FRAC_BITS
`timescale 1ns / 100ps
`default_nettype none

module mbbf_result_checker (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_we,
    input  wire mbbf_pkg::cfg_addr_t cfg_addr,
    input  wire [31:0]               cfg_wdata,
    input  wire                      s_valid,
    input  wire                      s_ready,
    input  wire signed [23:0]        s_sample_in,
    input  wire [2:0]                s_chan_index,
    input  wire                      m_valid,
    input  wire                      m_ready,
    input  wire signed [23:0]        m_sample_out,
    output int                       mismatches,
    output int                       pending
);

    import mbbf_pkg::*;

    localparam int CHANNELS = 8;
    localparam int SAMPLE_W = 24;

    // shadow copy of the configuration registers
    logic   enable_q;
    longint w_q;
    longint a1_q;
    longint a2_q;
    longint inv_a0_q;
    longint gain_q;

    // per-channel history
    longint x_prev1 [CHANNELS];
    longint x_prev2 [CHANNELS];
    longint band_z1 [CHANNELS];
    longint band_z2 [CHANNELS];

    // predicted samples still to come out, oldest first
    logic signed [23:0] expected_out [$];

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // product by a q8.24 coefficient, operand clamped to 32 bits, rounded half up
    function automatic longint qmul(input longint a, input longint c);
        longint p;
        p = clamp(a, 32) * c + (longint'(1) << (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    // one sample through the band section of its channel, updating the history; returned unchanged when disabled
    function logic signed [23:0] filter_sample(input logic signed [23:0] x,
                                               input logic [2:0] ch);
        longint xs;
        longint diff;
        longint acc;
        longint v;
        longint y;
        int     idx;
        xs  = longint'(x);
        idx = ch % CHANNELS;
        if (!enable_q) return x;
        diff = clamp(xs - x_prev2[idx], 32);
        x_prev2[idx] = x_prev1[idx];
        x_prev1[idx] = xs;
        acc = qmul(diff, w_q) - qmul(band_z1[idx], a1_q) - qmul(band_z2[idx], a2_q);
        v = clamp(qmul(acc, inv_a0_q), 32);
        band_z2[idx] = band_z1[idx];
        band_z1[idx] = v;
        y = clamp(qmul(v, gain_q), SAMPLE_W);
        return y[23:0];
    endfunction

    always @(posedge aclk) begin
        logic signed [23:0] want;
        if (!aresetn) begin
            enable_q = 1'b0;
            w_q      = 0;
            a1_q     = 0;
            a2_q     = 0;
            inv_a0_q = 0;
            gain_q   = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                x_prev1[i] = 0;
                x_prev2[i] = 0;
                band_z1[i] = 0;
                band_z2[i] = 0;
            end
            expected_out.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_addr)
                    REG_FILTER_ENABLE: enable_q = cfg_wdata[0];
                    REG_COEF_W:        w_q      = longint'($signed(cfg_wdata));
                    REG_COEF_A1:       a1_q     = longint'($signed(cfg_wdata));
                    REG_COEF_A2:       a2_q     = longint'($signed(cfg_wdata));
                    REG_COEF_INV_A0:   inv_a0_q = longint'($signed(cfg_wdata));
                    REG_BOOST_GAIN:    gain_q   = longint'($signed(cfg_wdata));
                    default: ;
                endcase
            end
            // output beat against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_out.size() == 0) begin
                    $display("%0t: sample_out expected none, got %0d", $time, m_sample_out);
                    mismatches++;
                end else begin
                    want = expected_out.pop_front();
                    if (m_sample_out !== want) begin
                        $display("%0t: sample_out expected %0d, got %0d",
                                 $time, want, m_sample_out);
                        mismatches++;
                    end
                end
            end
            // input beat
            if (s_valid && s_ready) begin
                expected_out.push_back(filter_sample(s_sample_in, s_chan_index));
            end
        end
        pending <= expected_out.size();
    end

endmodule

`default_nettype wire

/* test/multichannel_bandpass_boost_filter_test.sv */
// testbench top for the multichannel bandpass boost filter: clock, reset, register
// writes and sample stimulus with random gaps and stalls; verdict from mbbf_result_checker
// depends on mbbf_pkg, multichannel_bandpass_boost_filter and mbbf_result_checker
`timescale 1ns / 100ps
`default_nettype none

module multichannel_bandpass_boost_filter_test;

    import mbbf_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 12;

    // realistic coefficient set, q8.24
    localparam logic [31:0] W_TYP   = 32'sd2657511;
    localparam logic [31:0] A1_TYP  = -32'sd32712216;
    localparam logic [31:0] A2_TYP  = 32'sd15337731;
    localparam logic [31:0] INV_TYP = 32'sd14769180;
    localparam logic [31:0] G_TYP   = 32'sd35232154;
    localparam logic [31:0] C_MAX   = 32'h7fffffff;
    localparam logic [31:0] C_MIN   = 32'h80000000;

    logic               aclk;
    logic               aresetn      = 1'b0;
    logic               cfg_we       = 1'b0;
    cfg_addr_t          cfg_addr     = REG_FILTER_ENABLE;
    logic [31:0]        cfg_wdata    = '0;
    logic               s_valid      = 1'b0;
    wire                s_ready;
    logic signed [23:0] s_sample_in  = '0;
    logic [2:0]         s_chan_index = '0;
    wire                m_valid;
    logic               m_ready      = 1'b0;
    wire signed [23:0]  m_sample_out;

    logic idle_on = 1'b1;
    int   mismatches;
    int   results_pending;
    int   cycle_count = 0;

    multichannel_bandpass_boost_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .s_chan_index (s_chan_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    mbbf_result_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .s_chan_index (s_chan_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .mismatches   (mismatches),
        .pending      (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 27);
    end

    task automatic write_reg(input cfg_addr_t idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_all(input logic en, input logic [31:0] w, input logic [31:0] a1,
                             input logic [31:0] a2, input logic [31:0] inv,
                             input logic [31:0] gain);
        write_reg(REG_FILTER_ENABLE, {31'd0, en});
        write_reg(REG_COEF_W, w);
        write_reg(REG_COEF_A1, a1);
        write_reg(REG_COEF_A2, a2);
        write_reg(REG_COEF_INV_A0, inv);
        write_reg(REG_BOOST_GAIN, gain);
    endtask

    // hold the input side until every predicted sample has come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // one input beat, with an optional gap in front
    task automatic send_sample(input logic signed [23:0] x, input logic [2:0] ch);
        if (idle_on && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_sample_in  <= x;
        s_chan_index <= ch;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic signed [23:0] random_sample();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(3))
            0: return r[23:0];
            1: return 24'($signed(r[8:0]));
            2: return r[0] ? 24'sh7fffff : 24'sh800000;
            default: return 24'($signed(r[16:0]));
        endcase
    endfunction

    function automatic logic [31:0] modest_coef();
        return $signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
    endfunction

    // random beats; channel switches with the given chance, so low values give bursts
    task automatic run_items(input int count, input int switch_pct);
        logic [2:0] ch;
        ch = 3'($urandom_range(7));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < switch_pct) ch = 3'($urandom_range(7));
            send_sample(random_sample(), ch);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bypass straight after reset, extremes of both fields
        send_sample(24'sh7fffff, 3'd0);
        send_sample(24'sh800000, 3'd7);
        send_sample(24'sh000000, 3'd7);
        send_sample(-24'sd1, 3'd0);
        wait_idle();

        // impulse on one channel, others interleaved
        write_all(1'b1, W_TYP, A1_TYP, A2_TYP, INV_TYP, G_TYP);
        send_sample(24'sh7fffff, 3'd3);
        send_sample(24'sh800000, 3'd5);
        send_sample(24'sd0, 3'd3);
        send_sample(24'sd0, 3'd3);
        send_sample(24'sd0, 3'd3);
        send_sample(-24'sd1, 3'd3);
        send_sample(24'sd0, 3'd5);
        wait_idle();

        // saturation of band history and output, both signs
        write_all(1'b1, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX);
        send_sample(24'sh7fffff, 3'd1);
        send_sample(24'sh800000, 3'd1);
        send_sample(24'sh7fffff, 3'd1);
        send_sample(24'sh800000, 3'd1);
        wait_idle();
        write_reg(REG_BOOST_GAIN, C_MIN);
        send_sample(24'sh800000, 3'd2);
        send_sample(24'sh7fffff, 3'd2);
        send_sample(24'sh800000, 3'd1);
        wait_idle();

        // bypass keeps the history, which resumes on re-enable
        write_reg(REG_FILTER_ENABLE, 32'd0);
        send_sample(24'sd1234, 3'd1);
        send_sample(-24'sd1, 3'd6);
        wait_idle();
        write_all(1'b1, W_TYP, A1_TYP, A2_TYP, INV_TYP, G_TYP);
        send_sample(24'sd0, 3'd1);
        send_sample(24'sd100, 3'd3);
        send_sample(24'sd42, 3'd4);
        wait_idle();

        // random: realistic coefficients, with a drain halfway
        run_items(75, 100);
        wait_idle();
        run_items(75, 100);

        // long stretch with no gaps or stalls
        idle_on <= 1'b0;
        run_items(120, 100);
        wait_idle();
        idle_on <= 1'b1;

        // fully random coefficients
        write_all(1'b1, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        run_items(100, 50);
        wait_idle();

        // modest random coefficients
        write_all(1'b1, modest_coef(), modest_coef(), modest_coef(), modest_coef(),
                  modest_coef());
        run_items(100, 30);
        wait_idle();

        // bypass phase then back to filtering on the kept history
        write_reg(REG_FILTER_ENABLE, 32'd0);
        run_items(50, 100);
        wait_idle();
        write_reg(REG_FILTER_ENABLE, 32'd1);
        run_items(50, 20);
        wait_idle();

        // all-maximum and all-minimum coefficients
        write_all(1'b1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        run_items(50, 40);
        wait_idle();
        write_all(1'b1, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        run_items(50, 40);
        wait_idle();

        // channel bursts with realistic coefficients
        write_all(1'b1, W_TYP, A1_TYP, A2_TYP, INV_TYP, G_TYP);
        run_items(100, 10);
        wait_idle();

        if (mismatches == 0 && results_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
